>>> rtl/bdhe_pkg.sv
// Package for the button debounce and hold event block.
// Holds the item structs, event and quad mode codes, and the release code lookup.
// No dependencies.
package bdhe_pkg;

    localparam int FIELD_POS_W = 16;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;

    localparam logic [3:0] EV_NONE           = 4'd0;
    localparam logic [3:0] EV_QUAD_REL       = 4'd1;
    localparam logic [3:0] EV_CH1_REL        = 4'd3;
    localparam logic [3:0] EV_CH2_REL        = 4'd5;
    localparam logic [3:0] EV_SEL_REL        = 4'd7;
    localparam logic [3:0] EV_PAIR_REL       = 4'd9;
    localparam logic [3:0] EV_ROTATE         = 4'd11;
    localparam logic [3:0] EV_ROTATE_PRESSED = 4'd12;

    localparam logic [3:0] LV_NONE = 4'b0000;
    localparam logic [3:0] LV_CH1  = 4'b0001;
    localparam logic [3:0] LV_CH2  = 4'b0010;
    localparam logic [3:0] LV_PAIR = 4'b0011;
    localparam logic [3:0] LV_SEL  = 4'b0100;
    localparam logic [3:0] LV_QUAD = 4'b1000;

    localparam logic [1:0] QM_NORMAL  = 2'd0;
    localparam logic [1:0] QM_PRESSED = 2'd1;
    localparam logic [1:0] QM_ROTATED = 2'd2;

    typedef struct packed {
        logic                           operation;
        logic [3:0]                     switch_levels;
        logic signed [FIELD_POS_W-1:0]  encoder_position;
    } t_in_item;

    typedef struct packed {
        logic [3:0]                     event_code;
        logic signed [FIELD_POS_W-1:0]  rotation_delta;
    } t_out_item;

    function automatic logic [3:0] release_code(input logic [3:0] levels);
        logic [3:0] code;
        case (levels)
            LV_CH1:  code = EV_CH1_REL;
            LV_CH2:  code = EV_CH2_REL;
            LV_SEL:  code = EV_SEL_REL;
            LV_QUAD: code = EV_QUAD_REL;
            LV_PAIR: code = EV_PAIR_REL;
            default: code = EV_NONE;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/button_debounce_hold_events.sv
// Top level of the button debounce and hold event block.
// Depends on bdhe_pkg for the item structs, codes and the release code lookup.

// Each accepted item produces exactly one result item, which is in the result register in the next cycle. Poll items
// debounce the four switches with a saturating stable counter and give release or hold events;
// encoder items that move the position give a rotate event with the position change. The block takes one item
// in every cycle: all of its work is a single compare-and-update step between the state
// registers and the result register, and a new item is taken whenever the result
// register is empty or its item is being taken at the same edge.
module button_debounce_hold_events #(
    parameter int COUNT_WIDTH    = 16,
    parameter int POSITION_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bdhe_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bdhe_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [bdhe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdhe_pkg::TICK_W-1:0]         i_cfg_wdata
);
    import bdhe_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
    localparam int EXT_W = (POSITION_WIDTH > FIELD_POS_W) ? POSITION_WIDTH : FIELD_POS_W;

    logic [TICK_W-1:0]         r_debounce;
    logic [TICK_W-1:0]         r_hold;
    logic [COUNT_WIDTH-1:0]    r_count,    n_count;
    logic [3:0]                r_last,     n_last;
    logic [3:0]                r_armed,    n_armed;
    logic [1:0]                r_quad,     n_quad;
    logic [POSITION_WIDTH-1:0] r_pos,      n_pos;
    logic                      r_out_valid;
    t_out_item                 r_out_item, n_out_item;

    logic                      w_in_accept;
    logic [COUNT_WIDTH-1:0]    w_count_inc;
    logic [CMP_W-1:0]          w_count_cmp;
    logic [3:0]                w_rel;
    logic [EXT_W-1:0]          w_pos_ext;
    logic [POSITION_WIDTH-1:0] w_pos;
    logic [POSITION_WIDTH-1:0] w_delta;
    logic [EXT_W-1:0]          w_delta_ext;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_count_inc = (&r_count) ? r_count : r_count + 1'b1;
    assign w_count_cmp = CMP_W'(w_count_inc);
    assign w_rel       = release_code(i_in_item.switch_levels);
    assign w_pos_ext   = EXT_W'(i_in_item.encoder_position);
    assign w_pos       = w_pos_ext[POSITION_WIDTH-1:0];
    assign w_delta     = w_pos - r_pos;
    assign w_delta_ext = EXT_W'(signed'(w_delta));

    always_comb begin
        n_count    = r_count;
        n_last     = r_last;
        n_armed    = r_armed;
        n_quad     = r_quad;
        n_pos      = r_pos;
        n_out_item.event_code     = EV_NONE;
        n_out_item.rotation_delta = '0;
        if (i_in_item.operation == OP_POLL) begin
            n_count = w_count_inc;
            if (i_in_item.switch_levels != r_last) begin
                n_count = '0;
                n_last  = i_in_item.switch_levels;
            end else if (i_in_item.switch_levels == LV_NONE) begin
                if (r_armed != EV_NONE && r_quad != QM_ROTATED) begin
                    n_out_item.event_code = r_armed;
                end
                n_armed = EV_NONE;
                n_quad  = QM_NORMAL;
            end else if (w_count_cmp == CMP_W'(r_debounce)) begin
                n_armed = w_rel;
                if (i_in_item.switch_levels == LV_QUAD) begin
                    n_quad = QM_PRESSED;
                end
            end else if (w_count_cmp == CMP_W'(r_hold)) begin
                n_armed = EV_NONE;
                if (w_rel != EV_NONE && !(w_rel == EV_QUAD_REL && r_quad == QM_ROTATED)) begin
                    n_out_item.event_code = w_rel + 4'd1;
                end
            end
        end else if (w_delta != '0) begin
            n_out_item.rotation_delta = w_delta_ext[FIELD_POS_W-1:0];
            if (r_quad == QM_NORMAL) begin
                n_out_item.event_code = EV_ROTATE;
            end else begin
                n_quad = QM_ROTATED;
                n_out_item.event_code = EV_ROTATE_PRESSED;
            end
            n_pos = w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= TICK_W'(4);
            r_hold      <= TICK_W'(100);
            r_count     <= '0;
            r_last      <= LV_NONE;
            r_armed     <= EV_NONE;
            r_quad      <= QM_NORMAL;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                    REG_HOLD:     r_hold     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_in_accept) begin
                r_count     <= n_count;
                r_last      <= n_last;
                r_armed     <= n_armed;
                r_quad      <= n_quad;
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out_item <= n_out_item;
        end
    end

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_change_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in_item.operation == OP_POLL && i_in_item.switch_levels != r_last)
        |=> (r_count == '0))
        else $error("switch change did not clear the stable counter");

    a_delta_only_on_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.rotation_delta != '0)
        |-> (r_out_item.event_code == EV_ROTATE || r_out_item.event_code == EV_ROTATE_PRESSED))
        else $error("rotation delta on a non-rotate event");

    a_rotated_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && r_quad == QM_NORMAL && i_in_item.operation == OP_ENCODE)
        |=> (r_quad == QM_NORMAL))
        else $error("rotation changed quad mode while not pressed");

endmodule
